/* design/blpv_pkg.sv */
// shared types and constants for the blinn-phong vertex lighting block
// no dependencies; used by blpv_norm and the top level
package blpv_pkg;

    localparam int COMP_W    = 17;   // vector component before normalizing
    localparam int UNIT_W    = 16;   // signed q1.14 unit component
    localparam int UNIT_BITS = 14;
    localparam int UNIT_ONE  = 16384;
    localparam int NORM_LAT  = 43;   // register stages through blpv_norm
    localparam int SHINE_W   = 8;
    localparam int PW_STAGES = 2**SHINE_W - 1;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [UNIT_W-1:0] unit_t;

    typedef enum logic [2:0] {
        CFG_LIGHT_POS,
        CFG_VIEW_POINT,
        CFG_LIGHT_COLOR,
        CFG_AMBIENT_LIGHT,
        CFG_AMBIENT_COEFF,
        CFG_DIFFUSE_COEFF,
        CFG_SPECULAR_COEFF,
        CFG_SHININESS
    } cfg_idx_t;

endpackage

/* design/blpv_norm.sv */
// pipelined vector normalizer: scale, square sum, bit-serial root, divide
// depends on blpv_pkg; blpv_pkg::NORM_LAT register stages, advances on en
module blpv_norm (
    input  logic            clk,
    input  logic            en,
    input  blpv_pkg::comp_t vec  [3],
    output blpv_pkg::unit_t unit [3]
);

    localparam int MAG_W  = blpv_pkg::COMP_W;
    localparam int SC_W   = 21;
    localparam int SQ_W   = 2 * SC_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 4;
    localparam int Q_W    = blpv_pkg::UNIT_BITS + 1;
    localparam int DEN_W  = ROOT_W + 1;
    localparam int NUM_W  = SC_W + Q_W + 1;
    localparam int SH_W   = 5;

    typedef struct packed {
        logic [2:0][SC_W-1:0] sc;
        logic [2:0]           neg;
        logic                 zero;
    } side_t;

    // stage 1: magnitudes and largest magnitude
    logic [MAG_W-1:0] mag_c [3];
    logic [MAG_W-1:0] max_c;
    logic [MAG_W-1:0] mag1_reg [3];
    logic [2:0]       neg1_reg;
    logic [MAG_W-1:0] max1_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_c[k] = vec[k][MAG_W-1] ? MAG_W'(-vec[k]) : MAG_W'(vec[k]);
        end
        max_c = mag_c[0];
        if (mag_c[1] > max_c)
        begin
            max_c = mag_c[1];
        end
        if (mag_c[2] > max_c)
        begin
            max_c = mag_c[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mag1_reg[k] <= mag_c[k];
                neg1_reg[k] <= vec[k][MAG_W-1];
            end
            max1_reg <= max_c;
        end
    end

    // stage 2: power-of-two scale so the largest lands in [2^20, 2^21)
    logic [SH_W-1:0] shift_c;
    side_t           side2_reg;

    always_comb
    begin
        shift_c = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (max1_reg[i])
            begin
                shift_c = SH_W'(SC_W - 1 - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                side2_reg.sc[k] <= SC_W'({{(SC_W-MAG_W){1'b0}}, mag1_reg[k]} << shift_c);
            end
            side2_reg.neg  <= neg1_reg;
            side2_reg.zero <= (max1_reg == '0);
        end
    end

    // stage 3: squares
    logic [SQ_W-1:0] sq3_reg [3];
    side_t           side3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq3_reg[k] <= SQ_W'(side2_reg.sc[k]) * SQ_W'(side2_reg.sc[k]);
            end
            side3_reg <= side2_reg;
        end
    end

    // stage 4 and root stages: one result bit per stage
    logic [SUM_W-1:0]  x_reg     [ROOT_W+1];
    logic [REM_W-1:0]  rem_reg   [ROOT_W+1];
    logic [ROOT_W-1:0] root_reg  [ROOT_W+1];
    side_t             sside_reg [ROOT_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]     <= SUM_W'(sq3_reg[0]) + SUM_W'(sq3_reg[1]) + SUM_W'(sq3_reg[2]);
            rem_reg[0]   <= '0;
            root_reg[0]  <= '0;
            sside_reg[0] <= side3_reg;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_root
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;

        assign cur   = {rem_reg[j][REM_W-3:0], x_reg[j][SUM_W-1 -: 2]};
        assign trial = REM_W'({root_reg[j], 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[j+1]     <= x_reg[j] << 2;
                sside_reg[j+1] <= sside_reg[j];
                if (cur >= trial)
                begin
                    rem_reg[j+1]  <= cur - trial;
                    root_reg[j+1] <= {root_reg[j][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[j+1]  <= cur;
                    root_reg[j+1] <= {root_reg[j][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // divide setup and restoring divider, one quotient bit per stage
    logic [NUM_W-1:0] num_reg  [Q_W+1][3];
    logic [Q_W-1:0]   q_reg    [Q_W+1][3];
    logic [DEN_W-1:0] den_reg  [Q_W+1];
    logic [2:0]       dneg_reg [Q_W+1];
    logic             dzero_reg [Q_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                num_reg[0][k] <= NUM_W'({sside_reg[ROOT_W].sc[k], Q_W'(0)})
                               + NUM_W'(root_reg[ROOT_W]);
                q_reg[0][k]   <= '0;
            end
            den_reg[0]   <= {root_reg[ROOT_W], 1'b0};
            dneg_reg[0]  <= sside_reg[ROOT_W].neg;
            dzero_reg[0] <= sside_reg[ROOT_W].zero;
        end
    end

    for (genvar i = 0; i < Q_W; i++)
    begin : g_div
        logic [NUM_W-1:0] sub;

        assign sub = NUM_W'(den_reg[i]) << (Q_W - 1 - i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (num_reg[i][k] >= sub)
                    begin
                        num_reg[i+1][k] <= num_reg[i][k] - sub;
                        q_reg[i+1][k]   <= q_reg[i][k] | (Q_W'(1) << (Q_W - 1 - i));
                    end
                    else
                    begin
                        num_reg[i+1][k] <= num_reg[i][k];
                        q_reg[i+1][k]   <= q_reg[i][k];
                    end
                end
                den_reg[i+1]   <= den_reg[i];
                dneg_reg[i+1]  <= dneg_reg[i];
                dzero_reg[i+1] <= dzero_reg[i];
            end
        end
    end

    // output stage: sign back on, zero vector gives zero
    blpv_pkg::unit_t unit_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (dzero_reg[Q_W])
                begin
                    unit_reg[k] <= '0;
                end
                else if (dneg_reg[Q_W][k])
                begin
                    unit_reg[k] <= -blpv_pkg::UNIT_W'(q_reg[Q_W][k]);
                end
                else
                begin
                    unit_reg[k] <= blpv_pkg::UNIT_W'(q_reg[Q_W][k]);
                end
            end
        end
    end

    assign unit = unit_reg;

endmodule

/* design/blinn_phong_vertex_lighting_top.sv */
// top level of the blinn-phong vertex lighting pipeline
// depends on blpv_pkg and blpv_norm
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    vertex xyz, normal sum xyz (96 bits)
//  m_*       out  m_tvalid/m_tready    intensity red, green, blue (48 bits)
//  cfg_*     in   cfg_we               register index and 48-bit data
//
// one item per cycle sustained while the output is not stalled; the depth is set mostly by the 255
// stage power chain (one multiply per possible exponent step) and the two
// 43 stage normalizers (root and divide one bit per stage)
// reset clears the configuration registers (shininess is set to one) and all valid bits at once
// a stall at the output freezes the whole pipeline; nothing is lost or
// repeated, and the input is ready again as soon as the result is taken
module blinn_phong_vertex_lighting_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // vertex_x, vertex_y, vertex_z, normal_sum_x, normal_sum_y, normal_sum_z
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // intensity_red, intensity_green, intensity_blue
    output logic [47:0] m_tdata
);

    localparam int NL     = blpv_pkg::NORM_LAT;
    localparam int PW     = blpv_pkg::PW_STAGES;
    localparam int UB     = blpv_pkg::UNIT_BITS;
    localparam int IDX_D  = 2 * NL + 3;
    localparam int IDX_F  = IDX_D + PW + 1;
    localparam int TOTAL  = IDX_F + 2;

    function automatic blpv_pkg::comp_t ext(input logic [15:0] v);
        return {v[15], v};
    endfunction

    function automatic blpv_pkg::unit_t clamp_unit(input logic signed [31:0] v);
        if (v > blpv_pkg::UNIT_ONE)
        begin
            return blpv_pkg::unit_t'(blpv_pkg::UNIT_ONE);
        end
        if (v < -blpv_pkg::UNIT_ONE)
        begin
            return blpv_pkg::unit_t'(-blpv_pkg::UNIT_ONE);
        end
        return v[15:0];
    endfunction

    // configuration registers
    logic [47:0] lp_reg;
    logic [47:0] vp_reg;
    logic [47:0] lc_reg;
    logic [47:0] ia_reg;
    logic [15:0] ka_reg;
    logic [15:0] kd_reg;
    logic [15:0] ks_reg;
    logic [blpv_pkg::SHINE_W-1:0] shin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg   <= '0;
            vp_reg   <= '0;
            lc_reg   <= '0;
            ia_reg   <= '0;
            ka_reg   <= '0;
            kd_reg   <= '0;
            ks_reg   <= '0;
            shin_reg <= blpv_pkg::SHINE_W'(1);
        end
        else if (cfg_we)
        begin
            case (blpv_pkg::cfg_idx_t'(cfg_addr))
                blpv_pkg::CFG_LIGHT_POS:      lp_reg   <= cfg_wdata;
                blpv_pkg::CFG_VIEW_POINT:     vp_reg   <= cfg_wdata;
                blpv_pkg::CFG_LIGHT_COLOR:    lc_reg   <= cfg_wdata;
                blpv_pkg::CFG_AMBIENT_LIGHT:  ia_reg   <= cfg_wdata;
                blpv_pkg::CFG_AMBIENT_COEFF:  ka_reg   <= cfg_wdata[15:0];
                blpv_pkg::CFG_DIFFUSE_COEFF:  kd_reg   <= cfg_wdata[15:0];
                blpv_pkg::CFG_SPECULAR_COEFF: ks_reg   <= cfg_wdata[15:0];
                blpv_pkg::CFG_SHININESS:      shin_reg <= cfg_wdata[blpv_pkg::SHINE_W-1:0];
                default: ;
            endcase
        end
    end

    // material times colour products; the user must change them only while idle, not enforced here
    logic [31:0] kdc_reg  [3];
    logic [31:0] ksc_reg  [3];
    logic [31:0] kaia_reg [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            kdc_reg[k]  <= 32'(lc_reg[16*k +: 16]) * 32'(kd_reg);
            ksc_reg[k]  <= 32'(lc_reg[16*k +: 16]) * 32'(ks_reg);
            kaia_reg[k] <= 32'(ia_reg[16*k +: 16]) * 32'(ka_reg);
        end
    end

    // global advance: the pipeline moves unless a result is held at the output
    logic             en;
    logic [TOTAL-1:0] vld_reg;

    assign en       = !vld_reg[TOTAL-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[TOTAL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL-2:0], s_tvalid};
        end
    end

    // stage a: direction vectors toward light and viewer
    blpv_pkg::comp_t dl_reg [3];
    blpv_pkg::comp_t dv_reg [3];
    blpv_pkg::comp_t ns_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dl_reg[k] <= ext(lp_reg[16*k +: 16]) - ext(s_tdata[16*k +: 16]);
                dv_reg[k] <= ext(vp_reg[16*k +: 16]) - ext(s_tdata[16*k +: 16]);
                ns_reg[k] <= ext(s_tdata[48 + 16*k +: 16]);
            end
        end
    end

    blpv_pkg::unit_t un_c [3];
    blpv_pkg::unit_t ul_c [3];
    blpv_pkg::unit_t uv_c [3];
    blpv_pkg::unit_t uh_c [3];

    blpv_norm u_norm_n (.clk(clk), .en(en), .vec(ns_reg), .unit(un_c));
    blpv_norm u_norm_l (.clk(clk), .en(en), .vec(dl_reg), .unit(ul_c));
    blpv_norm u_norm_v (.clk(clk), .en(en), .vec(dv_reg), .unit(uv_c));

    // stage b: l + v for the half-way vector, n and l wait alongside
    blpv_pkg::comp_t lv_reg [3];
    blpv_pkg::unit_t un_dly_reg [NL+1][3];
    blpv_pkg::unit_t ul_dly_reg [NL+1][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lv_reg[k]        <= blpv_pkg::comp_t'(ul_c[k]) + blpv_pkg::comp_t'(uv_c[k]);
                un_dly_reg[0][k] <= un_c[k];
                ul_dly_reg[0][k] <= ul_c[k];
            end
            for (int s = 1; s <= NL; s++)
            begin
                un_dly_reg[s] <= un_dly_reg[s-1];
                ul_dly_reg[s] <= ul_dly_reg[s-1];
            end
        end
    end

    blpv_norm u_norm_h (.clk(clk), .en(en), .vec(lv_reg), .unit(uh_c));

    // stage c: dot product terms
    logic signed [31:0] pl_reg [3];
    logic signed [31:0] ph_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pl_reg[k] <= 32'(un_dly_reg[NL][k]) * 32'(ul_dly_reg[NL][k]);
                ph_reg[k] <= 32'(un_dly_reg[NL][k]) * 32'(uh_c[k]);
            end
        end
    end

    // stage d: round and clamp, then the power chain
    logic signed [31:0] sl_c;
    logic signed [31:0] sh_c;
    blpv_pkg::unit_t    nl_c;
    blpv_pkg::unit_t    nhs_c;
    logic [UB:0]        nh_c;

    always_comb
    begin
        sl_c  = (pl_reg[0] + pl_reg[1] + pl_reg[2] + 32'sd8192) >>> UB;
        sh_c  = (ph_reg[0] + ph_reg[1] + ph_reg[2] + 32'sd8192) >>> UB;
        nl_c  = clamp_unit(sl_c);
        nhs_c = clamp_unit(sh_c);
        nh_c  = nhs_c[blpv_pkg::UNIT_W-1] ? (UB+1)'(-nhs_c) : (UB+1)'(nhs_c);
    end

    logic [UB:0]     pw_reg [PW+1];
    logic [UB:0]     nh_reg [PW+1];
    blpv_pkg::unit_t nl_reg [PW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pw_reg[0] <= (UB+1)'(blpv_pkg::UNIT_ONE);
            nh_reg[0] <= nh_c;
            nl_reg[0] <= nl_c;
        end
    end

    // one multiply per exponent step; steps at or past the exponent pass through
    for (genvar e = 0; e < PW; e++)
    begin : g_pow
        logic [2*UB+1:0] prod;

        assign prod = (2*UB+2)'(pw_reg[e]) * (2*UB+2)'(nh_reg[e]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (blpv_pkg::SHINE_W'(e) < shin_reg)
                begin
                    pw_reg[e+1] <= (UB+1)'((prod + (2*UB+2)'(8192)) >> UB);
                end
                else
                begin
                    pw_reg[e+1] <= pw_reg[e];
                end
                nh_reg[e+1] <= nh_reg[e];
                nl_reg[e+1] <= nl_reg[e];
            end
        end
    end

    // stage f: diffuse and specular products per channel
    logic signed [48:0] td_reg [3];
    logic [46:0]        ts_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                td_reg[k] <= 49'($signed({1'b0, kdc_reg[k]})) * 49'(nl_reg[PW]);
                ts_reg[k] <= 47'(ksc_reg[k]) * 47'(pw_reg[PW]);
            end
        end
    end

    // stage g: sum with 30 extra fraction bits, round once, saturate
    logic signed [49:0] acc_c [3];
    logic signed [49:0] rnd_c [3];
    logic signed [15:0] ir_c  [3];
    logic [15:0]        ir_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc_c[k] = $signed({4'b0, kaia_reg[k], 14'b0}) + 50'(td_reg[k])
                     + $signed({3'b0, ts_reg[k]});
            rnd_c[k] = (acc_c[k] + 50'sd536870912) >>> 30;
            if (rnd_c[k] > 50'sd32767)
            begin
                ir_c[k] = 16'sh7fff;
            end
            else if (rnd_c[k] < -50'sd32768)
            begin
                ir_c[k] = 16'sh8000;
            end
            else
            begin
                ir_c[k] = rnd_c[k][15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ir_reg[k] <= ir_c[k];
            end
        end
    end

    assign m_tdata = {ir_reg[2], ir_reg[1], ir_reg[0]};

    // input is only held off by a result waiting at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // an accepted item enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted item lost at entry");

    // dot products stay within the unit range
    a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[IDX_D] |-> (nl_reg[0] <= blpv_pkg::UNIT_ONE
                            && nl_reg[0] >= -blpv_pkg::UNIT_ONE
                            && nh_reg[0] <= (UB+1)'(blpv_pkg::UNIT_ONE)))
        else $error("dot product out of range");

    // power never grows past one
    a_pow_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[IDX_F-1] |-> (pw_reg[PW] <= (UB+1)'(blpv_pkg::UNIT_ONE)))
        else $error("specular power above one");

endmodule

/* sim/tb.sv */
// self-checking testbench for blinn_phong_vertex_lighting_top
// needs blpv_pkg and the design sources; carries its own lighting predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DRAIN_CYCLES = 400;     // more than the pipeline depth
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  HOLD_CYCLES  = 1200;    // long output stall, well past pipe depth
    localparam int  RAND_PHASES  = 3;
    localparam int  PHASE_ITEMS  = 60;      // items in each idling phase
    localparam int  LONG_ITEMS   = 480;     // items in the free-running phase, past pipe depth

    typedef struct packed {
        logic signed [15:0] nz, ny, nx, vz, vy, vx;
    } vertex_t;

    typedef struct packed {
        logic signed [15:0] blue, green, red;
    } colour_t;

    typedef longint vec_t [3];

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    blpv_pkg::cfg_idx_t   cfg_addr = blpv_pkg::CFG_LIGHT_POS;
    logic [47:0]          cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    vertex_t              cur_vertex = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [47:0]          m_tdata;

    // shadow copies of the lighting registers
    logic [47:0] sh_light_pos = '0, sh_view = '0, sh_colour = '0, sh_ambient = '0;
    logic [15:0] sh_ka = '0, sh_kd = '0, sh_ks = '0;
    logic [7:0]  sh_shine = 8'd1;

    vertex_t     vertex_q [$];      // items waiting to be offered
    colour_t     shade_q [$];       // predicted intensities in flight
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_left = 0;
    int          fails = 0;
    int          cycles = 0;

    blinn_phong_vertex_lighting_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // vertex_x, vertex_y, vertex_z, normal_sum_x, normal_sum_y, normal_sum_z
        .s_tdata   (cur_vertex),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // intensity_red, intensity_green, intensity_blue
        .m_tdata   (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    // floor((v + 2^(s-1)) / 2^s), i.e. round half up
    function automatic longint round_shift(longint v, int s);
        longint t;
        t = v + (longint'(1) <<< (s - 1));
        if (t >= 0)
            return t >>> s;
        return -(((-t) + ((longint'(1) <<< s) - 1)) >>> s);
    endfunction

    function automatic longint root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // scale so the biggest component sits in [2^20, 2^21), then divide by length
    function automatic void to_unit(input vec_t d, output vec_t u);
        longint m, f, len, a, q;
        longint unsigned sq;
        vec_t sc;
        m = magn(d[0]);
        if (magn(d[1]) > m) m = magn(d[1]);
        if (magn(d[2]) > m) m = magn(d[2]);
        if (m == 0)
        begin
            u = '{0, 0, 0};
            return;
        end
        f = 1;
        while (m * f < (longint'(1) << 20))
            f = f * 2;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            sc[i] = d[i] * f;
            sq = sq + longint'(sc[i] * sc[i]);
        end
        len = root_floor(sq);
        for (int i = 0; i < 3; i++)
        begin
            a = magn(sc[i]) << (blpv_pkg::UNIT_BITS + 1);
            q = (a + len) / (2 * len);
            u[i] = (sc[i] < 0) ? -q : q;
        end
    endfunction

    function automatic longint unit_dot(vec_t a, vec_t b);
        longint s;
        s = round_shift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], blpv_pkg::UNIT_BITS);
        if (s > blpv_pkg::UNIT_ONE) s = blpv_pkg::UNIT_ONE;
        if (s < -blpv_pkg::UNIT_ONE) s = -blpv_pkg::UNIT_ONE;
        return s;
    endfunction

    function automatic colour_t shade_vertex(vertex_t v);
        vec_t vtx, nsum, to_light, to_view, lsum, un, ul, uv, uh;
        longint nl, nh, pw, acc, r, c, ia;
        logic signed [15:0] lp, vp;
        colour_t res;
        vtx  = '{v.vx, v.vy, v.vz};
        nsum = '{v.nx, v.ny, v.nz};
        for (int k = 0; k < 3; k++)
        begin
            lp = sh_light_pos[16*k +: 16];
            vp = sh_view[16*k +: 16];
            to_light[k] = lp - vtx[k];
            to_view[k]  = vp - vtx[k];
        end
        to_unit(nsum, un);
        to_unit(to_light, ul);
        to_unit(to_view, uv);
        for (int k = 0; k < 3; k++)
            lsum[k] = ul[k] + uv[k];
        to_unit(lsum, uh);
        nl = unit_dot(un, ul);
        nh = magn(unit_dot(un, uh));
        pw = blpv_pkg::UNIT_ONE;
        for (int e = 0; e < sh_shine; e++)
            pw = round_shift(pw * nh, blpv_pkg::UNIT_BITS);
        for (int k = 0; k < 3; k++)
        begin
            c   = sh_colour[16*k +: 16];
            ia  = sh_ambient[16*k +: 16];
            acc = longint'(sh_ka) * ia * blpv_pkg::UNIT_ONE + c * longint'(sh_kd) * nl
                + c * longint'(sh_ks) * pw;
            r = round_shift(acc, 16 + blpv_pkg::UNIT_BITS);
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            res[16*k +: 16] = r[15:0];
        end
        return res;
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk)
    begin
        logic    nxt_valid;
        vertex_t nxt_vertex;
        nxt_valid  = s_tvalid;
        nxt_vertex = cur_vertex;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                shade_q.insert(shade_q.size(), shade_vertex(cur_vertex));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && vertex_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                nxt_vertex = vertex_q.pop_front();
                nxt_valid  = 1'b1;
            end
        end
        s_tvalid   <= nxt_valid;
        cur_vertex <= nxt_vertex;
    end

    // ---------------- receiver with optional long hold-off ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        colour_t got, want;
        got = m_tdata;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (shade_q.size() == 0)
            begin
                $error("result with nothing expected: %h", m_tdata);
                fails++;
            end
            else
            begin
                want = shade_q.pop_front();
                if (got.red !== want.red)
                begin
                    $error("intensity_red expected %0d got %0d", want.red, got.red);
                    fails++;
                end
                if (got.green !== want.green)
                begin
                    $error("intensity_green expected %0d got %0d", want.green, got.green);
                    fails++;
                end
                if (got.blue !== want.blue)
                begin
                    $error("intensity_blue expected %0d got %0d", want.blue, got.blue);
                    fails++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- sequencing ----------------

    task automatic write_reg(blpv_pkg::cfg_idx_t idx, logic [47:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            blpv_pkg::CFG_LIGHT_POS:      sh_light_pos = val;
            blpv_pkg::CFG_VIEW_POINT:     sh_view      = val;
            blpv_pkg::CFG_LIGHT_COLOR:    sh_colour    = val;
            blpv_pkg::CFG_AMBIENT_LIGHT:  sh_ambient   = val;
            blpv_pkg::CFG_AMBIENT_COEFF:  sh_ka        = val[15:0];
            blpv_pkg::CFG_DIFFUSE_COEFF:  sh_kd        = val[15:0];
            blpv_pkg::CFG_SPECULAR_COEFF: sh_ks        = val[15:0];
            blpv_pkg::CFG_SHININESS:      sh_shine     = val[7:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every offered item has produced its result, sampled between edges
    task automatic drain();
        while (vertex_q.size() > 0 || s_tvalid || shade_q.size() > 0)
            @(negedge clk);
    endtask

    function automatic void queue_vertex(vertex_t v);
        vertex_q.insert(vertex_q.size(), v);
    endfunction

    function automatic vertex_t mk_vertex(logic [15:0] vx, vy, vz, nx, ny, nz);
        vertex_t v;
        v.vx = vx; v.vy = vy; v.vz = vz;
        v.nx = nx; v.ny = ny; v.nz = nz;
        return v;
    endfunction

    // values spread over all magnitudes so both small and full range vectors occur
    function automatic logic [15:0] rand_q88();
        logic [15:0] r;
        r = $urandom;
        return $signed(r) >>> $urandom_range(15);
    endfunction

    function automatic logic [47:0] rand_packed();
        return {rand_q88(), rand_q88(), rand_q88()};
    endfunction

    task automatic random_setup(int ph);
        write_reg(blpv_pkg::CFG_LIGHT_POS, rand_packed());
        write_reg(blpv_pkg::CFG_VIEW_POINT, rand_packed());
        write_reg(blpv_pkg::CFG_LIGHT_COLOR, 48'({$urandom, $urandom}));
        write_reg(blpv_pkg::CFG_AMBIENT_LIGHT, 48'({$urandom, $urandom}));
        write_reg(blpv_pkg::CFG_AMBIENT_COEFF, 48'($urandom));
        write_reg(blpv_pkg::CFG_DIFFUSE_COEFF, 48'($urandom));
        write_reg(blpv_pkg::CFG_SPECULAR_COEFF, 48'($urandom));
        // include both exponent extremes among the phases
        write_reg(blpv_pkg::CFG_SHININESS, (ph == 0) ? 48'd0 : (ph == 1) ? 48'd255
                                           : 48'($urandom_range(12)));
        end_writes();
    endtask

    initial
    begin
        vertex_t v;
        int      n_items;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: light at +1 on x, viewer at -1 on x, so L+V vanishes at the origin
        write_reg(blpv_pkg::CFG_LIGHT_POS, 48'h0000_0000_0100);
        write_reg(blpv_pkg::CFG_VIEW_POINT, 48'h0000_0000_ff00);
        write_reg(blpv_pkg::CFG_LIGHT_COLOR, 48'hffff_ffff_ffff);
        write_reg(blpv_pkg::CFG_AMBIENT_LIGHT, 48'hffff_ffff_ffff);
        write_reg(blpv_pkg::CFG_AMBIENT_COEFF, 48'hffff);
        write_reg(blpv_pkg::CFG_DIFFUSE_COEFF, 48'hffff);
        write_reg(blpv_pkg::CFG_SPECULAR_COEFF, 48'hffff);
        write_reg(blpv_pkg::CFG_SHININESS, 48'h0);
        end_writes();
        @(negedge clk);
        queue_vertex(mk_vertex(0, 0, 0, 16'h0100, 0, 0));       // half-way vector zero
        queue_vertex(mk_vertex(0, 0, 0, 0, 0, 0));              // zero normal sum
        queue_vertex(mk_vertex(16'h0100, 0, 0, 0, 16'h0100, 0)); // vertex at the light
        queue_vertex(mk_vertex(0, 0, 0, 16'hff00, 0, 0));       // negative diffuse
        queue_vertex(mk_vertex(16'h8000, 16'h8000, 16'h8000,
                               16'h8000, 16'h8000, 16'h8000));
        queue_vertex(mk_vertex(16'h7fff, 16'h7fff, 16'h7fff,
                               16'h7fff, 16'h7fff, 16'h7fff));
        queue_vertex(mk_vertex(16'h7fff, 16'h8000, 16'h0001,
                               16'h0001, 16'hffff, 16'h8000));
        drain();

        // directed: steepest exponent, light and viewer at opposite corners
        write_reg(blpv_pkg::CFG_LIGHT_POS, 48'h7fff_7fff_7fff);
        write_reg(blpv_pkg::CFG_VIEW_POINT, 48'h8000_8000_8000);
        write_reg(blpv_pkg::CFG_AMBIENT_COEFF, 48'h0);
        write_reg(blpv_pkg::CFG_SHININESS, 48'hff);
        end_writes();
        @(negedge clk);
        queue_vertex(mk_vertex(0, 0, 0, 16'h0100, 16'h0100, 16'h0100));
        queue_vertex(mk_vertex(0, 0, 0, 16'hff00, 16'h0100, 0));
        queue_vertex(mk_vertex(16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 16'h0001));
        queue_vertex(mk_vertex(16'h8000, 16'h8000, 16'h8000, 16'h0001, 0, 0));
        queue_vertex(mk_vertex(16'h0001, 16'hffff, 0, 16'h7fff, 16'h8000, 0));
        drain();

        // random phases: mostly the receiver idles, then mostly the sender, then a free-running stream
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            random_setup(ph);
            @(negedge clk);
            send_idle = (ph == 0) ? 36 : (ph == 1) ? 61 : 0;
            recv_idle = (ph == 0) ? 61 : (ph == 1) ? 36 : 0;
            n_items   = (ph == 2) ? LONG_ITEMS : PHASE_ITEMS;
            for (int i = 0; i < n_items; i++)
            begin
                v = {rand_q88(), rand_q88(), rand_q88(), rand_q88(), rand_q88(), rand_q88()};
                // now and then put the vertex on the light or the viewer
                if ($urandom_range(19) == 0)
                    {v.vz, v.vy, v.vx} = ($urandom_range(1) != 0) ? sh_light_pos : sh_view;
                if ($urandom_range(29) == 0)
                    {v.nz, v.ny, v.nx} = '0;
                queue_vertex(v);
            end
            // output stall while items are still offered, so the pipe backs up to the input
            if (ph == 2)
                hold_left = HOLD_CYCLES;
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && shade_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
design/blpv_pkg.sv
design/blpv_norm.sv
design/blinn_phong_vertex_lighting_top.sv
sim/tb.sv
